// ----- design/gtg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants for the gyro tilt gesture detector.
// ----------------------------------------------------------------------------
package gtg_pkg;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_WAKE  = 2'd1,
		REQ_SLEEP = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		MODE_OFF      = 2'd0,
		MODE_NORMAL   = 2'd1,
		MODE_INVERTED = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ORIENT_PORTRAIT   = 3'd0,
		ORIENT_INVERTED   = 3'd1,
		ORIENT_LAND_CW    = 3'd2,
		ORIENT_LAND_CCW   = 3'd3
	} orient_t;

	typedef enum logic [2:0] {
		REG_SENSOR_PRESENT = 3'd0,
		REG_TILT_MODE      = 3'd1,
		REG_ORIENTATION    = 3'd2,
		REG_RATE_THRESHOLD = 3'd3,
		REG_NEUTRAL_RATE   = 3'd4,
		REG_TRIG_HOLDOFF   = 3'd5,
		REG_POLL_INTERVAL  = 3'd6,
		REG_WAKE_SETTLE    = 3'd7
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;

	localparam logic        RST_SENSOR_PRESENT = 1'b1;
	localparam logic [1:0]  RST_TILT_MODE      = 2'd0;
	localparam logic [2:0]  RST_ORIENTATION    = 3'd0;
	localparam logic [14:0] RST_RATE_THRESHOLD = 15'd6400;
	localparam logic [14:0] RST_NEUTRAL_RATE   = 15'd1280;
	localparam logic [15:0] RST_TRIG_HOLDOFF   = 16'd500;
	localparam logic [15:0] RST_POLL_INTERVAL  = 16'd50;
	localparam logic [15:0] RST_WAKE_SETTLE    = 16'd200;

	typedef struct packed {
		logic        sensor_present;
		logic [1:0]  tilt_mode;
		logic [2:0]  orientation;
		logic [14:0] rate_threshold;
		logic [14:0] neutral_rate;
		logic [15:0] trig_holdoff;
		logic [15:0] poll_gap;
		logic [15:0] wake_settle_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  command;
		logic        in_reader;
		logic        sample_ok;
		logic        write_ok;
		logic [15:0] rate_x;
		logic [15:0] rate_y;
	} item_t;

	typedef struct packed {
		logic forward_event;
		logic back_event;
		logic activity;
		req_t sensor_request;
		logic awake;
		logic tilt_held;
	} res_t;

endpackage
`default_nettype wire

// ----- design/gtg_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module gtg_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [gtg_pkg::CFG_DATA_W-1:0] cfg_data,
	output gtg_pkg::cfg_t                       cfg
);
	import gtg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_present   <= RST_SENSOR_PRESENT;
			cfg_q.tilt_mode        <= RST_TILT_MODE;
			cfg_q.orientation      <= RST_ORIENTATION;
			cfg_q.rate_threshold   <= RST_RATE_THRESHOLD;
			cfg_q.neutral_rate     <= RST_NEUTRAL_RATE;
			cfg_q.trig_holdoff     <= RST_TRIG_HOLDOFF;
			cfg_q.poll_gap         <= RST_POLL_INTERVAL;
			cfg_q.wake_settle_ms   <= RST_WAKE_SETTLE;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SENSOR_PRESENT: cfg_q.sensor_present   <= cfg_data[0];
				REG_TILT_MODE:      cfg_q.tilt_mode        <= cfg_data[1:0];
				REG_ORIENTATION:    cfg_q.orientation      <= cfg_data[2:0];
				REG_RATE_THRESHOLD: cfg_q.rate_threshold   <= cfg_data[14:0];
				REG_NEUTRAL_RATE:   cfg_q.neutral_rate     <= cfg_data[14:0];
				REG_TRIG_HOLDOFF:   cfg_q.trig_holdoff     <= cfg_data;
				REG_POLL_INTERVAL:  cfg_q.poll_gap         <= cfg_data;
				REG_WAKE_SETTLE:    cfg_q.wake_settle_ms   <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- design/gtg_axis_sel.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_axis_sel
// Picks the gyro axis for page turning and signs it by orientation and mode.
// ----------------------------------------------------------------------------
module gtg_axis_sel (
	input  wire logic [2:0]         orientation,
	input  wire logic               inv,
	input  wire logic signed [15:0] rate_x,
	input  wire logic signed [15:0] rate_y,
	output logic signed [16:0]      axis
);
	import gtg_pkg::*;

	logic signed [16:0] gx;
	logic signed [16:0] gy;

	// Seventeen bits keep the negation of the most negative sample exact.
	assign gx = 17'(rate_x);
	assign gy = 17'(rate_y);

	always_comb begin
		case (orientation)
			ORIENT_PORTRAIT: axis = inv ? -gx : gx;
			ORIENT_INVERTED: axis = inv ? gx : -gx;
			ORIENT_LAND_CW:  axis = inv ? gy : -gy;
			ORIENT_LAND_CCW: axis = inv ? -gy : gy;
			default:         axis = gx;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/gtg_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_engine
// Timekeeping, wake/sleep sequencing, poll gating and tilt detection state.
// ----------------------------------------------------------------------------
module gtg_engine #(
	parameter int unsigned SLEEP_SETTLE_MS = 100
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire gtg_pkg::item_t item,
	input  wire gtg_pkg::cfg_t  cfg,
	output gtg_pkg::res_t       res
);
	import gtg_pkg::*;

	localparam logic [31:0] SETTLE = 32'(SLEEP_SETTLE_MS);

	logic [31:0] time_q, sleep_q, wake_q, poll_q, tilt_q;
	logic [31:0] time_d, sleep_d, wake_d, poll_d, tilt_d;
	logic        awake_q, awake_d, hold_q, hold_d;
	logic [2:0]  pend_q, pend_d;

	logic        active, inv;
	logic [31:0] d_sleep, d_wake, d_poll, d_tilt;
	logic signed [16:0] axis, mag, thr, neg_thr, neutral;
	req_t        req;
	logic [2:0]  shown;

	assign active  = (cfg.tilt_mode != MODE_OFF) && item.in_reader;
	assign inv     = (cfg.tilt_mode == MODE_INVERTED);
	assign d_sleep = time_q - sleep_q;
	assign d_wake  = time_q - wake_q;
	assign d_poll  = time_q - poll_q;
	assign d_tilt  = time_q - tilt_q;

	gtg_axis_sel u_axis (
		.orientation (cfg.orientation),
		.inv         (inv),
		.rate_x      ($signed(item.rate_x)),
		.rate_y      ($signed(item.rate_y)),
		.axis        (axis)
	);

	assign mag     = axis[16] ? -axis : axis;
	assign thr     = $signed({2'b00, cfg.rate_threshold});
	assign neg_thr = -thr;
	assign neutral = $signed({2'b00, cfg.neutral_rate});

	always_comb begin
		time_d  = time_q;
		sleep_d = sleep_q;
		wake_d  = wake_q;
		poll_d  = poll_q;
		tilt_d  = tilt_q;
		awake_d = awake_q;
		hold_d  = hold_q;
		pend_d  = pend_q;
		req     = REQ_NONE;
		unique case (cmd_t'(item.command))
			CMD_TICK: begin
				time_d = time_q + 32'd1;
			end
			CMD_UPDATE: begin
				if (cfg.sensor_present) begin
					if (active && !awake_q) begin
						if (d_sleep >= SETTLE) begin
							req = REQ_WAKE;
							if (item.write_ok) begin
								poll_d  = time_q;
								tilt_d  = time_q;
								wake_d  = time_q;
								awake_d = 1'b1;
							end
						end
					end else if (!active && awake_q) begin
						if (d_wake >= SETTLE) begin
							req = REQ_SLEEP;
							if (item.write_ok) begin
								pend_d  = '0;
								hold_d  = 1'b0;
								sleep_d = time_q;
								awake_d = 1'b0;
							end
						end
					end else if (active) begin
						if (d_wake >= 32'(cfg.wake_settle_ms) &&
								d_poll >= 32'(cfg.poll_gap)) begin
							poll_d = time_q;
							if (item.sample_ok) begin
								if (hold_q) begin
									if (mag < neutral) hold_d = 1'b0;
								end else if (d_tilt >= 32'(cfg.trig_holdoff)) begin
									// Bit 0 forward, bit 1 back, bit 2 activity.
									if (axis > thr) begin
										pend_d = pend_q | 3'b101;
										hold_d = 1'b1;
										tilt_d = time_q;
									end else if (axis < neg_thr) begin
										pend_d = pend_q | 3'b110;
										hold_d = 1'b1;
										tilt_d = time_q;
									end
								end
							end
						end
					end
				end
			end
			CMD_READ: begin
				pend_d = '0;
			end
			default: begin
			end
		endcase
	end

	// A read shows the flags as they were before clearing.
	assign shown = (cmd_t'(item.command) == CMD_READ) ? pend_q : pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			sleep_q <= '0;
			wake_q  <= '0;
			poll_q  <= '0;
			tilt_q  <= '0;
			awake_q <= 1'b0;
			hold_q  <= 1'b0;
			pend_q  <= '0;
		end else if (fire) begin
			time_q  <= time_d;
			sleep_q <= sleep_d;
			wake_q  <= wake_d;
			poll_q  <= poll_d;
			tilt_q  <= tilt_d;
			awake_q <= awake_d;
			hold_q  <= hold_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		res.forward_event  = shown[0];
		res.back_event     = shown[1];
		res.activity       = shown[2];
		res.sensor_request = req;
		res.awake          = awake_d;
		res.tilt_held      = hold_d;
	end

endmodule
`default_nettype wire

// ----- design/gyro_tilt_gesture_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_tilt_gesture_detector
// Gyro rate threshold gesture detector with hysteresis, cooldown, poll gating
// and wake/sleep sequencing, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Path: an accepted input transaction is held in the input register, then its
// result is valid once it is loaded into the result register.
// Throughput: one transaction per cycle unless stalled; state is updated as
// an item leaves the input register, so each item sees the prior one's state.
// Reset: arst_n clears time, stamps, flags and handshake state at once and
// loads the configuration registers with their default values.
module gyro_tilt_gesture_detector #(
	parameter int unsigned SLEEP_SETTLE_MS = 100
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [gtg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     command,
	input  wire logic                           in_reader,
	input  wire logic                           sample_ok,
	input  wire logic                           write_ok,
	input  wire logic signed [15:0]             rate_x,
	input  wire logic signed [15:0]             rate_y,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                forward_event,
	output logic                                back_event,
	output logic                                activity,
	output logic [1:0]                          sensor_request,
	output logic                                awake,
	output logic                                tilt_held
);
	import gtg_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  out_free;
	logic  adv;
	logic  in_take;

	gtg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.command   <= command;
			item_s1.in_reader <= in_reader;
			item_s1.sample_ok <= sample_ok;
			item_s1.write_ok  <= write_ok;
			item_s1.rate_x    <= rate_x;
			item_s1.rate_y    <= rate_y;
		end
		if (adv) res_s2 <= res;
	end

	gtg_engine #(
		.SLEEP_SETTLE_MS (SLEEP_SETTLE_MS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid      = valid_s2;
	assign forward_event  = res_s2.forward_event;
	assign back_event     = res_s2.back_event;
	assign activity       = res_s2.activity;
	assign sensor_request = res_s2.sensor_request;
	assign awake          = res_s2.awake;
	assign tilt_held      = res_s2.tilt_held;

	// A held tilt is only possible while the sensor is awake.
	a_hold_awake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tilt_held |-> awake)
		else $error("tilt held while asleep");

	// Every direction event carries the activity mark.
	a_event_act: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (forward_event || back_event) |-> activity)
		else $error("direction event without activity");

	// An empty result register never holds back the input side.
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

endmodule
`default_nettype wire
